[hw/rtl/srht_pkg.sv]
package srht_pkg;

  // Coordinate format: signed Q12.4
  localparam int COORD_BITS = 16;
  // Differences of two coordinates need one more bit
  localparam int DIFF_W     = COORD_BITS + 1;
  // Cross products of two differences
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NUM_BND    = 4;
  localparam int APB_DW     = 32;
  localparam int ADDR_W     = 4;
  // Entry register plus two registers in each boundary cell
  localparam int PIPE_DEPTH = 1 + 2 * NUM_BND;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // Per-segment clip state handed from cell to cell.
  // Entry parameter t0 = n0/d0, exit parameter t1 = n1/d1, d0 and d1 > 0.
  typedef struct packed {
    diff_t [NUM_BND-1:0] p;
    diff_t [NUM_BND-1:0] q;
    diff_t               n0;
    diff_t               d0;
    diff_t               n1;
    diff_t               d1;
    logic                alive;
  } clip_t;

  // Cell-internal state after the multiply stage
  typedef struct packed {
    clip_t base;
    prod_t num_d1;
    prod_t n1_den;
    prod_t num_d0;
    prod_t n0_den;
    diff_t num;
    diff_t den;
    logic  p_zero;
    logic  p_neg;
    logic  q_neg;
  } mul_t;

endpackage

[hw/rtl/srht_ifs.sv]
interface srht_seg_if;
  logic               valid;
  logic               ready;
  srht_pkg::coord_t   start_x;
  srht_pkg::coord_t   start_y;
  srht_pkg::coord_t   end_x;
  srht_pkg::coord_t   end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface srht_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

[hw/rtl/srht_regs.sv]
module srht_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srht_pkg::ADDR_W-1:0]   paddr,
  input  logic [srht_pkg::APB_DW-1:0]   pwdata,
  output logic [srht_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output srht_pkg::rect_t               rect
);
  import srht_pkg::*;

  reg_idx_t idx;
  logic     wr_en;
  coord_t   wr_val;
  coord_t   rd_val;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = coord_t'(pwdata[COORD_BITS-1:0]);
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rect <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT:   rect.left   <= wr_val;
        REG_TOP:    rect.top    <= wr_val;
        REG_RIGHT:  rect.right  <= wr_val;
        REG_BOTTOM: rect.bottom <= wr_val;
      endcase
    end
  end

  // Readback, sign-extended to the bus
  always_comb begin
    unique case (idx)
      REG_LEFT:   rd_val = rect.left;
      REG_TOP:    rd_val = rect.top;
      REG_RIGHT:  rd_val = rect.right;
      REG_BOTTOM: rd_val = rect.bottom;
    endcase
  end

  assign prdata = APB_DW'(rd_val);

endmodule

[hw/rtl/srht_cell.sv]
module srht_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srht_pkg::clip_t   in_data,
  input  srht_pkg::diff_t   bnd_p,
  input  srht_pkg::diff_t   bnd_q,
  output logic              out_valid,
  input  logic              out_ready,
  output srht_pkg::clip_t   out_data
);
  import srht_pkg::*;

  logic  mul_valid;
  mul_t  mul;
  mul_t  mul_next;
  logic  mul_ready;
  clip_t out_next;

  // Stage ready: a register can load when empty or draining
  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;

  // Multiply stage: orient the boundary fraction and form cross products
  always_comb begin
    mul_next.base   = in_data;
    mul_next.p_zero = (bnd_p == '0);
    mul_next.p_neg  = bnd_p[DIFF_W-1];
    mul_next.q_neg  = bnd_q[DIFF_W-1];
    mul_next.num    = bnd_p[DIFF_W-1] ? -bnd_q : bnd_q;
    mul_next.den    = bnd_p[DIFF_W-1] ? -bnd_p : bnd_p;
    mul_next.num_d1 = PROD_W'(mul_next.num) * PROD_W'(in_data.d1);
    mul_next.n1_den = PROD_W'(in_data.n1) * PROD_W'(mul_next.den);
    mul_next.num_d0 = PROD_W'(mul_next.num) * PROD_W'(in_data.d0);
    mul_next.n0_den = PROD_W'(in_data.n0) * PROD_W'(mul_next.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul <= mul_next;
    end
  end

  // Compare stage: reject or narrow [t0, t1]
  always_comb begin
    out_next = mul.base;
    if (mul.base.alive) begin
      priority if (mul.p_zero) begin
        if (mul.q_neg) out_next.alive = 1'b0;
      end else if (mul.p_neg) begin
        // entering edge: t > t1 rejects, t > t0 raises t0
        if (mul.num_d1 > mul.n1_den) begin
          out_next.alive = 1'b0;
        end else if (mul.num_d0 > mul.n0_den) begin
          out_next.n0 = mul.num;
          out_next.d0 = mul.den;
        end
      end else begin
        // leaving edge: t < t0 rejects, t < t1 lowers t1
        if (mul.num_d0 < mul.n0_den) begin
          out_next.alive = 1'b0;
        end else if (mul.num_d1 < mul.n1_den) begin
          out_next.n1 = mul.num;
          out_next.d1 = mul.den;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid) begin
      out_data <= out_next;
    end
  end

endmodule

[hw/rtl/segment_rectangle_hit_test.sv]
// Channel   | Dir | Payload                          | Transfer
// ----------+-----+----------------------------------+-------------------
// seg_in    | in  | start_x start_y end_x end_y (Q12.4) | valid & ready
// hit_out   | out | hit                              | valid & ready
// APB       | in  | rect_left/top/right/bottom @ 0,4,8,12 | psel&penable&pwrite
//
// One segment per cycle sustained while hit_out is ready; each segment passes the entry
// register, then a multiply and a compare register in each of the four boundary cells.
// Every stage loads when empty or draining, so bubbles close up under stall.
// Synchronous reset empties the pipe and clears the rectangle to zero.
// A stalled hit_out holds its result; seg_in.ready drops once the pipe is full.
module segment_rectangle_hit_test (
  input  logic                          clk,
  input  logic                          rst,
  srht_seg_if.sink                      seg_in,
  srht_hit_if.source                    hit_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srht_pkg::ADDR_W-1:0]   paddr,
  input  logic [srht_pkg::APB_DW-1:0]   pwdata,
  output logic [srht_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import srht_pkg::*;

  rect_t rect;
  logic  entry_valid;
  clip_t entry;
  clip_t entry_next;
  diff_t dx;
  diff_t dy;

  logic  [NUM_BND:0] link_valid;
  logic  [NUM_BND:0] link_ready;
  clip_t [NUM_BND:0] link_data;

  srht_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rect    (rect)
  );

  // Entry stage: boundary distances and directions, t0 = 0/1, t1 = 1/1
  assign dx = diff_t'(seg_in.end_x) - diff_t'(seg_in.start_x);
  assign dy = diff_t'(seg_in.end_y) - diff_t'(seg_in.start_y);

  always_comb begin
    entry_next.p[0]  = -dx;
    entry_next.p[1]  = dx;
    entry_next.p[2]  = -dy;
    entry_next.p[3]  = dy;
    entry_next.q[0]  = diff_t'(seg_in.start_x) - diff_t'(rect.left);
    entry_next.q[1]  = diff_t'(rect.right) - diff_t'(seg_in.start_x);
    entry_next.q[2]  = diff_t'(seg_in.start_y) - diff_t'(rect.top);
    entry_next.q[3]  = diff_t'(rect.bottom) - diff_t'(seg_in.start_y);
    entry_next.n0    = '0;
    entry_next.d0    = diff_t'(1);
    entry_next.n1    = diff_t'(1);
    entry_next.d1    = diff_t'(1);
    entry_next.alive = 1'b1;
  end

  assign seg_in.ready = !entry_valid || link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (seg_in.ready) begin
      entry_valid <= seg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_in.ready && seg_in.valid) begin
      entry <= entry_next;
    end
  end

  assign link_valid[0] = entry_valid;
  assign link_data[0]  = entry;

  // Boundary cells in order left, right, top, bottom
  for (genvar i = 0; i < NUM_BND; i++) begin : g_cell
    srht_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .bnd_p     (link_data[i].p[i]),
      .bnd_q     (link_data[i].q[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  assign hit_out.valid        = link_valid[NUM_BND];
  assign hit_out.hit          = link_data[NUM_BND].alive;
  assign link_ready[NUM_BND]  = hit_out.ready;

endmodule

[hw/rtl/srht_checker.sv]
module srht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [srht_pkg::ADDR_W-1:0]   paddr,
  input logic [srht_pkg::APB_DW-1:0]   pwdata,
  input logic [srht_pkg::APB_DW-1:0]   prdata,
  input logic                          pready
);
  import srht_pkg::*;

  coord_t                   shadow [NUM_BND];
  logic [CNT_W-1:0]         in_flight;
  logic                     in_xfer;
  logic                     out_xfer;
  logic                     wr_xfer;
  logic [APB_DW-1:0]        rd_expect;
  logic                     rect_inverted;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign wr_xfer  = psel && penable && pwrite && pready;

  // Shadow copy of the rectangle as seen on the bus
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BND; i++) shadow[i] <= '0;
    end else if (wr_xfer) begin
      shadow[paddr[3:2]] <= coord_t'(pwdata[COORD_BITS-1:0]);
    end
  end

  // Items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  assign rd_expect     = APB_DW'(shadow[paddr[3:2]]);
  assign rect_inverted = (shadow[REG_RIGHT] < shadow[REG_LEFT]) ||
                         (shadow[REG_BOTTOM] < shadow[REG_TOP]);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != '0)
    else $error("result without an accepted segment");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(PIPE_DEPTH))
    else $error("more segments in flight than pipeline stages");

  a_inverted: assert property (@(posedge clk) disable iff (rst)
    out_valid && rect_inverted |-> !hit)
    else $error("hit reported for inverted rectangle");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite |-> prdata == rd_expect)
    else $error("register readback mismatch");

endmodule

bind segment_rectangle_hit_test srht_checker u_srht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (seg_in.valid),
  .in_ready  (seg_in.ready),
  .out_valid (hit_out.valid),
  .out_ready (hit_out.ready),
  .hit       (hit_out.hit),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

[bench/tb_segment_rectangle_hit_test.sv]
module tb_segment_rectangle_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srht_pkg::*;

  localparam int CMIN         = -(2 ** (COORD_BITS - 1));
  localparam int CMAX         = 2 ** (COORD_BITS - 1) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 36;
  localparam int NUM_DIRECTED = 21;

  // Exact clip test against a private copy of the rectangle, plus the
  // queue of hit flags still owed by the block.
  class hit_scoreboard;
    coord_t left, top, right, bottom;
    bit     hit_q[$];
    int     errors;

    function new();
      left   = '0;
      top    = '0;
      right  = '0;
      bottom = '0;
      errors = 0;
    endfunction

    function void set_edge(reg_idx_t idx, coord_t v);
      case (idx)
        REG_LEFT:   left   = v;
        REG_TOP:    top    = v;
        REG_RIGHT:  right  = v;
        REG_BOTTOM: bottom = v;
        default: ;
      endcase
    endfunction

    // Liang-Barsky with t kept as num/den (den > 0); products fit in 64 bits
    function bit clip_hit(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      longint p[4];
      longint q[4];
      longint n0, d0, n1, d1, num, den;
      n0 = 0; d0 = 1; n1 = 1; d1 = 1;
      p[0] = -(longint'(bx) - longint'(ax));
      p[1] = longint'(bx) - longint'(ax);
      p[2] = -(longint'(by) - longint'(ay));
      p[3] = longint'(by) - longint'(ay);
      q[0] = longint'(ax) - longint'(left);
      q[1] = longint'(right) - longint'(ax);
      q[2] = longint'(ay) - longint'(top);
      q[3] = longint'(bottom) - longint'(ay);
      for (int i = 0; i < 4; i++) begin
        // parallel boundary: outside means no contact at all
        if (p[i] == 0) begin
          if (q[i] < 0) return 1'b0;
          continue;
        end
        num = (p[i] < 0) ? -q[i] : q[i];
        den = (p[i] < 0) ? -p[i] : p[i];
        if (p[i] < 0) begin
          // entering: t must not pass t1, raise t0
          if (num * d1 > n1 * den) return 1'b0;
          if (num * d0 > n0 * den) begin
            n0 = num;
            d0 = den;
          end
        end else begin
          // leaving: t must not drop below t0, lower t1
          if (num * d0 < n0 * den) return 1'b0;
          if (num * d1 < n1 * den) begin
            n1 = num;
            d1 = den;
          end
        end
      end
      return 1'b1;
    endfunction

    function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      hit_q = {hit_q, clip_hit(sx, sy, ex, ey)};
    endfunction

    function void check_hit(logic got);
      bit want;
      if (hit_q.size() == 0) begin
        $display("%0t: hit transfer with none expected: expected none, actual %b",
                 $time, got);
        errors++;
      end else begin
        want = hit_q.pop_front();
        if (got !== want) begin
          $display("%0t: hit mismatch: expected %0b, actual %b", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return hit_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  bit                  no_gaps;
  int                  stall_cycles;
  hit_scoreboard       sb = new();

  srht_seg_if seg_bus ();
  srht_hit_if hit_bus ();

  segment_rectangle_hit_test u_dut (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg_bus),
    .hit_out (hit_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Directed segments, checked against rectangle (-160,-80)..(320,240)
  int dir_seg [0:NUM_DIRECTED-1][0:3] = '{
    '{-32768, -32768,  32767,  32767},  // full-range diagonal through it
    '{ 32767, -32768, -32768,  32767},  // opposite diagonal
    '{     0,      0,      0,      0},  // point inside
    '{   400,      0,    400,      0},  // point outside
    '{  -160,    -80,   -160,    -80},  // point on min corner
    '{   320,    240,    320,    240},  // point on max corner
    '{  -500,    -81,    500,    -81},  // horizontal just above
    '{  -500,    -80,    500,    -80},  // horizontal on top edge
    '{   321,   -500,    321,    500},  // vertical just right
    '{   320,   -500,    320,    500},  // vertical on right edge
    '{  -400,      0,   -160,      0},  // ends on left edge
    '{  -400,      0,   -161,      0},  // stops one LSB short
    '{   300,    260,    340,    220},  // grazes max corner
    '{   301,    261,    341,    221},  // misses max corner by one
    '{  -500,    100,    500,    100},  // straight through
    '{  -200,    -60,   -140,   -120},  // diagonal past min corner
    '{-32768,  32767, -32768, -32768},  // far-left vertical, field extremes
    '{ 32767,  32767,  32767,  32767},  // point at max coordinate
    '{  -160,      0,   -400,      0},  // starts on left edge, leaves
    '{     0,      0,    100,    100},  // fully inside
    '{     0,      0,  32767, -32768}   // starts inside, exits far away
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random backpressure, check every transfer
  initial begin
    hit_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hit_bus.valid && hit_bus.ready) sb.check_hit(hit_bus.hit);
      hit_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || psel || (seg_bus.valid && seg_bus.ready) ||
        (hit_bus.valid && hit_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Coordinate around [a,b] with a margin, clamped; edges picked often
  function automatic coord_t near_span(coord_t a, coord_t b);
    int lo, hi, m, l2, h2;
    lo = (a < b) ? int'(a) : int'(b);
    hi = (a < b) ? int'(b) : int'(a);
    if ($urandom_range(5) == 0) return ($urandom_range(1) != 0) ? a : b;
    m  = (hi - lo) / 2 + 16;
    l2 = (lo - m < CMIN) ? CMIN : lo - m;
    h2 = (hi + m > CMAX) ? CMAX : hi + m;
    return coord_t'(l2 + int'($urandom_range(h2 - l2)));
  endfunction

  task automatic pick_segment(output coord_t sx, output coord_t sy,
                              output coord_t ex, output coord_t ey);
    int kind;
    kind = $urandom_range(9);
    sx = near_span(sb.left, sb.right);
    sy = near_span(sb.top, sb.bottom);
    ex = near_span(sb.left, sb.right);
    ey = near_span(sb.top, sb.bottom);
    case (kind)
      0, 1: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      6: begin
        // degenerate segment
        ex = sx;
        ey = sy;
      end
      7: ey = sy;
      8: ex = sx;
      9: begin
        // one endpoint on a rectangle corner
        sx = ($urandom_range(1) != 0) ? sb.left : sb.right;
        sy = ($urandom_range(1) != 0) ? sb.top : sb.bottom;
      end
      default: ;
    endcase
  endtask

  // Offer one segment, with random gaps ahead of it
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      seg_bus.valid <= 1'b0;
      do @(posedge clk); while (!no_gaps && $urandom_range(99) < IDLE_PCT);
    end
    seg_bus.valid   <= 1'b1;
    seg_bus.start_x <= sx;
    seg_bus.start_y <= sy;
    seg_bus.end_x   <= ex;
    seg_bus.end_y   <= ey;
    do @(posedge clk); while (!seg_bus.ready);
    sb.note_segment(sx, sy, ex, ey);
  endtask

  task automatic drain_results();
    seg_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_random(int count, int hold_at);
    coord_t sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) drain_results();
      pick_segment(sx, sy, ex, ey);
      send_segment(sx, sy, ex, ey);
    end
    drain_results();
  endtask

  // APB write; random bits above the field must be ignored
  task automatic write_reg(reg_idx_t idx, coord_t v);
    logic [APB_DW-1:0] w;
    w = $urandom;
    w[COORD_BITS-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_edge(idx, v);
    @(posedge clk);
  endtask

  task automatic read_reg(reg_idx_t idx, coord_t want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COORD_BITS-1:0] !== want) begin
      $display("%0t: %s read mismatch: expected %h, actual %h",
               $time, idx.name(), want, prdata[COORD_BITS-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rect(int l, int t, int r, int b);
    write_reg(REG_LEFT,   coord_t'(l));
    write_reg(REG_TOP,    coord_t'(t));
    write_reg(REG_RIGHT,  coord_t'(r));
    write_reg(REG_BOTTOM, coord_t'(b));
    read_reg(REG_LEFT,   coord_t'(l));
    read_reg(REG_TOP,    coord_t'(t));
    read_reg(REG_RIGHT,  coord_t'(r));
    read_reg(REG_BOTTOM, coord_t'(b));
  endtask

  // Main sequence
  initial begin
    int a, b, c, d, tmp;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    seg_bus.valid   <= 1'b0;
    seg_bus.start_x <= '0;
    seg_bus.start_y <= '0;
    seg_bus.end_x   <= '0;
    seg_bus.end_y   <= '0;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rectangle after reset is the single point at the origin
    run_random(12, -1);

    // directed cases
    set_rect(-160, -80, 320, 240);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_segment(coord_t'(dir_seg[i][0]), coord_t'(dir_seg[i][1]),
                   coord_t'(dir_seg[i][2]), coord_t'(dir_seg[i][3]));
    drain_results();

    // random ordinary rectangle; sender holds off midway until drained
    a = int'($urandom_range(8000)) - 4000;
    b = int'($urandom_range(8000)) - 4000;
    c = int'($urandom_range(8000)) - 4000;
    d = int'($urandom_range(8000)) - 4000;
    if (a > b) begin tmp = a; a = b; b = tmp; end
    if (c > d) begin tmp = c; c = d; d = tmp; end
    set_rect(a, c, b, d);
    run_random(80, 40);

    // whole coordinate space, back to back with no gaps on either side
    no_gaps = 1'b1;
    set_rect(CMIN, CMIN, CMAX, CMAX);
    run_random(60, -1);
    no_gaps = 1'b0;

    // inverted in x, then in y: nothing can hit
    set_rect(100, -50, -100, 50);
    run_random(45, -1);
    set_rect(-50, 100, 50, -100);
    run_random(45, -1);

    // zero-width rectangle
    a = int'($urandom_range(2000)) - 1000;
    c = int'($urandom_range(2000)) - 1000;
    d = c + int'($urandom_range(1500));
    set_rect(a, c, a, d);
    run_random(55, -1);

    // point rectangle on the max corner of the space
    set_rect(CMAX, CMAX, CMAX, CMAX);
    run_random(50, -1);

    // small rectangle against the min corner
    set_rect(CMIN, CMIN, CMIN + 600, CMIN + 200);
    run_random(60, 30);

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[segment_rectangle_hit_test.f]
hw/rtl/srht_pkg.sv
hw/rtl/srht_ifs.sv
hw/rtl/srht_regs.sv
hw/rtl/srht_cell.sv
hw/rtl/segment_rectangle_hit_test.sv
hw/rtl/srht_checker.sv
bench/tb_segment_rectangle_hit_test.sv
